@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL; they expect clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is asserted
`define BIDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies an outcome in the next
`define BIDS_ASSERT_NEXT(label, pre, post, msg) \
	`BIDS_ASSERT(label, (pre) |=> (post), msg)

`endif

@@ design/bids_pkg.sv @@
// ----------------------------------------------------------------------------
// bids_pkg
// Widths, request codes and word layout of the bounded id set.
// ----------------------------------------------------------------------------
`default_nettype none

package bids_pkg;

	// Set geometry
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int ID_W     = 32;
	localparam int MODE_W   = 2;
	localparam int POS_W    = 6;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [ID_W-1:0]  NULL_ID = '1;

	// Request codes
	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_ADD = 2'd0;
	localparam mode_t MODE_DEL = 2'd1;
	localparam mode_t MODE_HAS = 2'd2;
	localparam mode_t MODE_GET = 2'd3;

	// Word layout
	localparam int IN_FIELD_W  = ID_W + POS_W;
	localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = 1 + 1 + ID_W + CNT_W + 1 + 1;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

endpackage

`default_nettype wire

@@ design/bounded_id_set_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_id_set_unit
// Fixed-capacity unordered set of 32-bit ids in a packed table with one read port,
// searched one slot per cycle by a shared compare unit.
// ----------------------------------------------------------------------------
// Operation: add, delete and contains compare the stored ids in slot order
//   through the single read port (up to 64 slots); an add miss appends the id,
//   a delete hit moves the last id into the hole; get reads one slot; rejects
//   skip the scan. A new request is taken only once the last result is loaded.
// Reset: arst_n clears the count and all control at once; no clearing pass,
//   slots at or above the count read as the null id.
`default_nettype none

`include "assert_macros.svh"

module bounded_id_set_unit import bids_pkg::*; (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	// request side
	input  wire  logic                  s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] id (signed), [37:32] position, [39:38] zero
	input  wire  logic [MODE_W-1:0]     s_axis_tuser,  // [1:0] mode
	// result side
	output logic                        m_axis_tvalid,
	input  wire  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]       m_axis_tdata   // [0] status, [1] found, [33:2] id_out (signed),
	                                                   // [40:34] count, [41] full_res, [42] empty_res,
	                                                   // [47:43] zero
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_MOVE = 3'd3;
	localparam logic [2:0] ST_GET  = 3'd4;
	localparam logic [2:0] ST_GETW = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  cmp_vld_s1;
	logic [ADDR_W-1:0]     cmp_idx_s1;
	logic [ADDR_W-1:0]     slot_q;
	mode_t                 mode_q;
	logic [ID_W-1:0]       key_q;
	logic [POS_W-1:0]      pos_q;
	logic                  res_status_q;
	logic                  res_found_q;
	logic [ID_W-1:0]       res_id_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [ID_W-1:0]       mem_q [CAPACITY];
	logic [ID_W-1:0]       rdata_q;

	logic                  in_acc;
	mode_t                 in_mode;
	logic [ID_W-1:0]       in_id;
	logic [POS_W-1:0]      in_pos;
	logic                  in_null;
	logic                  out_free;
	logic                  cmp_hit;
	logic                  scan_end;
	logic                  scan_issue;
	logic [CNT_W-1:0]      last_idx;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ID_W-1:0]       wr_data;
	logic                  out_load;

	// Handshake and field unpacking
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_mode       = s_axis_tuser;
	assign in_id         = s_axis_tdata[ID_W-1:0];
	assign in_pos        = s_axis_tdata[ID_W +: POS_W];
	assign in_null       = (in_id == NULL_ID);
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && out_free;

	// Shared compare unit, one slot behind the read address
	assign cmp_hit    = cmp_vld_s1 && (rdata_q == key_q);
	assign scan_end   = !cmp_vld_s1 && (rd_idx_q == count_q);
	assign scan_issue = (state_q == ST_SCAN) && !cmp_hit && (rd_idx_q < count_q);
	assign last_idx   = count_q - 1'b1;

	// Table port selection
	always_comb begin
		rd_addr = rd_idx_q[ADDR_W-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = key_q;
		case (state_q)
			ST_SCAN: begin
				wr_en = !cmp_hit && scan_end && (mode_q == MODE_ADD);
			end
			ST_LAST: begin
				rd_addr = last_idx[ADDR_W-1:0];
			end
			ST_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = rdata_q;
			end
			ST_GET: begin
				rd_addr = pos_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Id table, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// Sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					rd_idx_q   <= '0;
					if (in_acc) begin
						case (in_mode)
							MODE_ADD: state_q <= (in_null || count_q == CAP_CNT) ?
								ST_DONE : ST_SCAN;
							MODE_DEL: state_q <= (in_null || count_q == '0) ?
								ST_DONE : ST_SCAN;
							MODE_HAS: state_q <= in_null ? ST_DONE : ST_SCAN;
							MODE_GET: state_q <= ST_GET;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= scan_issue;
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (cmp_hit) begin
						state_q <= (mode_q == MODE_DEL) ? ST_LAST : ST_DONE;
					end else if (scan_end) begin
						if (mode_q == MODE_ADD) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_LAST: begin
					cmp_vld_s1 <= 1'b0;
					state_q    <= ST_MOVE;
				end
				ST_MOVE: begin
					count_q <= last_idx;
					state_q <= ST_DONE;
				end
				ST_GET: begin
					state_q <= ST_GETW;
				end
				ST_GETW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					cmp_vld_s1 <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request operands and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= in_mode;
			key_q        <= in_id;
			pos_q        <= in_pos;
			res_found_q  <= 1'b0;
			res_id_q     <= NULL_ID;
			case (in_mode)
				MODE_ADD: res_status_q <= in_null || (count_q == CAP_CNT);
				MODE_DEL: res_status_q <= in_null || (count_q == '0);
				default:  res_status_q <= 1'b0;
			endcase
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= rd_idx_q[ADDR_W-1:0];
			if (cmp_hit) begin
				slot_q <= cmp_idx_s1;
				if (mode_q == MODE_HAS) begin
					res_found_q <= 1'b1;
				end
			end else if (scan_end && mode_q == MODE_DEL) begin
				res_status_q <= 1'b1;
			end
		end
		if (state_q == ST_GETW) begin
			res_id_q <= (CNT_W'(pos_q) < count_q) ? rdata_q : NULL_ID;
		end
		if (out_load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, (count_q == '0), (count_q == CAP_CNT), count_q,
				res_id_q, res_found_q, res_status_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// Checks
	`BIDS_ASSERT(a_count_bound, count_q <= CAP_CNT, "count above capacity")
	`BIDS_ASSERT(a_scan_range, (state_q == ST_SCAN) |-> (rd_idx_q <= count_q), "scan past count")
	`BIDS_ASSERT(a_cmp_range, cmp_vld_s1 |-> (CNT_W'(cmp_idx_s1) < count_q),
		"compare outside stored slots")
	`BIDS_ASSERT_NEXT(a_del_dec, state_q == ST_MOVE, count_q == $past(count_q) - 1'b1, "delete count")
	`BIDS_ASSERT_NEXT(a_add_inc, wr_en && (state_q == ST_SCAN), count_q == $past(count_q) + 1'b1,
		"add count")

endmodule

`default_nettype wire

@@ tb/bounded_id_set_unit_test.sv @@
// ----------------------------------------------------------------------------
// bounded_id_set_unit_test
// Self-checking bench for the bounded id set. A shadow copy of the set
// predicts every result word. Directed requests cover the corner cases, then
// fill/empty sequences and weighted random mixes run with random gaps and
// stalls on both streams, but for one random mix that runs without them.
// ----------------------------------------------------------------------------
module bounded_id_set_unit_test import bids_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int MAX_REPORTS    = 10;
	localparam int POOL_SIZE      = 96;

	// One result word, split into its fields
	typedef struct packed {
		logic             status;
		logic             found;
		logic [ID_W-1:0]  id_out;
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} set_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Shadow copy of the set and the words it still owes us
	logic [ID_W-1:0] shadow_ids [CAPACITY];
	int              shadow_count;
	set_result_t     pending_results [$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	int mismatches = 0;
	int quiet_cycles = 0;
	int ready_hold = 0;
	bit idling = 1'b1;

	bounded_id_set_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Slot holding key among the stored ids, -1 if absent
	function automatic int find_id(logic [ID_W-1:0] key);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_ids[i] == key) return i;
		end
		return -1;
	endfunction

	// Apply one request to the shadow set and return the word it produces
	function automatic set_result_t apply_request(mode_t mode, logic [ID_W-1:0] key,
			logic [POS_W-1:0] pos);
		set_result_t r;
		int slot;
		r = '{status: 1'b0, found: 1'b0, id_out: NULL_ID, count: '0, full: 1'b0,
			empty: 1'b0};
		slot = find_id(key);
		case (mode)
			MODE_ADD: begin
				// full set rejects even an id already present
				if (key == NULL_ID || shadow_count >= CAPACITY) begin
					r.status = 1'b1;
				end else if (slot < 0) begin
					shadow_ids[shadow_count] = key;
					shadow_count++;
				end
			end
			MODE_DEL: begin
				if (key == NULL_ID || slot < 0) begin
					r.status = 1'b1;
				end else begin
					// last entry fills the hole
					shadow_ids[slot] = shadow_ids[shadow_count-1];
					shadow_ids[shadow_count-1] = NULL_ID;
					shadow_count--;
				end
			end
			MODE_HAS: begin
				r.found = (key != NULL_ID) && (slot >= 0);
			end
			default: begin
				if (pos < CAPACITY) r.id_out = shadow_ids[pos];
			end
		endcase
		r.count = CNT_W'(shadow_count);
		r.full  = (shadow_count == CAPACITY);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (!idling) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Operand: sometimes null, often a stored id, else fresh or from the pool
	function automatic logic [ID_W-1:0] pick_id(bit prefer_stored);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return NULL_ID;
		if (prefer_stored && shadow_count > 0 && r < 60)
			return shadow_ids[$urandom_range(0, shadow_count-1)];
		if (r < 70) return {1'b0, 31'($urandom)};
		return id_pool[$urandom_range(0, POOL_SIZE-1)];
	endfunction

	// Send one request word; valid stays high afterwards until the next call
	task automatic send_request(mode_t mode, logic [ID_W-1:0] key, logic [POS_W-1:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({pos, key});
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_request(mode, key, pos));
	endtask

	// Hold off the sender until every owed word has come back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic refill_pool();
		foreach (id_pool[i]) id_pool[i] = {1'b0, 31'($urandom)};
	endtask

	// Corner cases on a small set
	task automatic test_directed();
		idling = 1'b1;
		send_request(MODE_GET, '0, 6'd0);
		send_request(MODE_HAS, NULL_ID, 6'd0);
		send_request(MODE_ADD, NULL_ID, 6'd0);
		send_request(MODE_DEL, 32'd5, 6'd0);
		send_request(MODE_ADD, 32'd0, 6'd63);
		send_request(MODE_ADD, 32'h7FFF_FFFF, 6'd0);
		send_request(MODE_ADD, 32'd12345, 6'd21);
		send_request(MODE_ADD, 32'd0, 6'd42);
		send_request(MODE_HAS, 32'h7FFF_FFFF, 6'd0);
		send_request(MODE_HAS, 32'd99, 6'd0);
		send_request(MODE_HAS, NULL_ID, 6'd0);
		send_request(MODE_GET, NULL_ID, 6'd0);
		send_request(MODE_GET, '0, 6'd1);
		send_request(MODE_GET, '0, 6'd2);
		send_request(MODE_GET, '0, 6'd63);
		send_request(MODE_DEL, NULL_ID, 6'd0);
		send_request(MODE_DEL, 32'd99, 6'd0);
		send_request(MODE_DEL, 32'd0, 6'd0);
		send_request(MODE_GET, '0, 6'd0);
		send_request(MODE_DEL, 32'd12345, 6'd0);
		send_request(MODE_DEL, 32'h7FFF_FFFF, 6'd0);
		send_request(MODE_HAS, 32'd0, 6'd0);
		wait_for_results();
	endtask

	// Fill to capacity, then hit the full set
	task automatic test_fill_to_capacity();
		logic [ID_W-1:0] kept;
		idling = 1'b1;
		while (shadow_count < CAPACITY)
			send_request(MODE_ADD, {1'b0, 31'($urandom)}, 6'($urandom));
		kept = shadow_ids[$urandom_range(0, CAPACITY-1)];
		send_request(MODE_ADD, {1'b0, 31'($urandom)}, 6'd0);
		send_request(MODE_ADD, kept, 6'd0);
		send_request(MODE_HAS, kept, 6'd0);
		send_request(MODE_GET, '0, 6'd63);
		send_request(MODE_DEL, kept, 6'd0);
		send_request(MODE_GET, '0, 6'd63);
		send_request(MODE_ADD, kept, 6'd0);
		wait_for_results();
	endtask

	// Delete everything in random order, then poke the empty set
	task automatic test_drain_to_empty();
		idling = 1'b1;
		while (shadow_count > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_request(MODE_GET, pick_id(1'b0), 6'($urandom));
			else
				send_request(MODE_DEL, shadow_ids[$urandom_range(0, shadow_count-1)],
					6'($urandom));
		end
		send_request(MODE_DEL, {1'b0, 31'($urandom)}, 6'd0);
		send_request(MODE_HAS, {1'b0, 31'($urandom)}, 6'd0);
		send_request(MODE_GET, '0, 6'd0);
		wait_for_results();
	endtask

	// Weighted random mix; get takes whatever the other weights leave
	task automatic test_random_mix(int items, int w_add, int w_del, int w_has, bit with_idle);
		int r;
		mode_t mode;
		logic [ID_W-1:0] key;
		logic [POS_W-1:0] pos;
		idling = with_idle;
		refill_pool();
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < w_add) mode = MODE_ADD;
			else if (r < w_add + w_del) mode = MODE_DEL;
			else if (r < w_add + w_del + w_has) mode = MODE_HAS;
			else mode = MODE_GET;
			key = pick_id(mode != MODE_ADD || $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7)
				pos = POS_W'($urandom_range(0, (shadow_count < CAPACITY) ?
					shadow_count : CAPACITY-1));
			else
				pos = POS_W'($urandom);
			send_request(mode, key, pos);
		end
		wait_for_results();
	endtask

	// Receiver: stalls of random length while idling is on
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (idling && $urandom_range(0, 2) == 0) begin
			m_axis_tready <= 1'b0;
			ready_hold = pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold = idling ? $urandom_range(0, 8) : 0;
		end
	end

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin
		set_result_t got;
		set_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{status: m_axis_tdata[0], found: m_axis_tdata[1],
				id_out: m_axis_tdata[33:2], count: m_axis_tdata[40:34],
				full: m_axis_tdata[41], empty: m_axis_tdata[42]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result word with nothing expected: %p", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected status %0b found %0b id %h count %0d full %0b empty %0b",
							want.status, want.found, want.id_out, want.count, want.full,
							want.empty);
						$display("  actual   status %0b found %0b id %h count %0d full %0b empty %0b",
							got.status, got.found, got.id_out, got.count, got.full, got.empty);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		foreach (shadow_ids[i]) shadow_ids[i] = NULL_ID;
		shadow_count = 0;
		refill_pool();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_to_capacity();
		test_drain_to_empty();
		test_random_mix(300, 35, 25, 25, 1'b1);
		test_random_mix(250, 70, 10, 10, 1'b1);
		test_random_mix(250, 15, 55, 15, 1'b1);
		test_random_mix(200, 35, 25, 25, 1'b0);
		test_random_mix(100, 30, 30, 20, 1'b1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
